// ===== sv/f2h_pkg.sv =====
// ----------------------------------------------------------------------------
// Conversion package
// Shared constants and conversion functions for the binary32/binary16 unit.
// ----------------------------------------------------------------------------
package f2h_pkg;

    localparam int unsigned OperandWidth = 32;
    localparam int unsigned ResultWidth  = 32;

    localparam logic [15:0] HalfInf    = 16'h7c00;
    localparam logic [15:0] HalfSign   = 16'h8000;
    localparam logic [15:0] HalfFrac   = 16'h03ff;
    localparam logic [12:0] LowMask    = 13'h1fff;
    localparam logic [12:0] LowHalf    = 13'h1000;
    localparam logic [23:0] HiddenBit  = 24'h800000;
    localparam logic [31:0] SingleInf  = 32'h7f800000;
    localparam logic [22:0] SingleFrac = 23'h7fffff;

    localparam logic KindToHalf   = 1'b0;
    localparam logic KindToSingle = 1'b1;

    function automatic logic [15:0] single_to_half(input logic [31:0] bits);
        logic [15:0] sign;
        logic [7:0]  ebits;
        logic [22:0] frac;
        logic [23:0] mant;
        logic [4:0]  shift;
        logic [47:0] wide;
        logic [23:0] kept_s;
        logic [23:0] rest_s;
        logic [23:0] half_s;
        logic [9:0]  kept;
        logic [12:0] rest;
        logic [9:0]  payload;
        logic [15:0] res;
        logic [10:0] sum;
        sign  = bits[31] ? HalfSign : 16'h0000;
        ebits = bits[30:23];
        frac  = bits[22:0] & SingleFrac;
        mant  = HiddenBit | {1'b0, frac};
        shift = 5'd0;
        wide  = '0;
        kept_s = '0;
        rest_s = '0;
        half_s = '0;
        kept  = frac[22:13];
        rest  = frac[12:0] & LowMask;
        payload = frac[22:13];
        sum   = '0;
        if (ebits == 8'hff) begin
            if (frac == 23'd0) begin
                res = sign | HalfInf;
            end else begin
                if (payload == 10'd0) begin
                    payload = 10'd1;
                end
                res = sign | HalfInf | {6'd0, payload};
            end
        end else if (ebits >= 8'd143) begin
            res = sign | HalfInf;
        end else if (ebits <= 8'd112) begin
            if (ebits < 8'd102) begin
                res = sign;
            end else begin
                shift  = 5'd14 + 5'(8'd112 - ebits);
                wide   = {mant, 24'd0} >> shift;
                kept_s = wide[47:24];
                rest_s = wide[23:0];
                half_s = 24'h800000;
                if (rest_s > half_s || (rest_s == half_s && kept_s[0])) begin
                    kept_s = kept_s + 24'd1;
                end
                res = sign | kept_s[15:0];
            end
        end else begin
            sum = {1'b0, kept};
            if (rest > LowHalf || (rest == LowHalf && kept[0])) begin
                sum = sum + 11'd1;
            end
            res = sign | ({11'd0, 5'(ebits - 8'd112)} << 10);
            res = res + {5'd0, sum};
            if (res[14:10] == 5'h1f) begin
                res = sign | HalfInf;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  ebits;
        logic [9:0]  frac;
        logic [3:0]  lz;
        logic [10:0] norm;
        logic [31:0] res;
        sign  = h[15] ? 32'h80000000 : 32'd0;
        ebits = h[14:10];
        frac  = h[9:0] & HalfFrac[9:0];
        lz    = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (frac[i]) begin
                lz = 4'(9 - i);
            end
        end
        norm = {1'b0, frac} << (lz + 4'd1);
        if (ebits == 5'd0) begin
            if (frac == 10'd0) begin
                res = sign;
            end else begin
                res = sign | ({24'd0, 8'(8'd112 - {4'd0, lz})} << 23)
                    | ({22'd0, norm[9:0]} << 13);
            end
        end else if (ebits == 5'h1f) begin
            res = sign | SingleInf | ({22'd0, frac} << 13);
        end else begin
            res = sign | ({24'd0, 8'({3'd0, ebits} + 8'd112)} << 23)
                | ({22'd0, frac} << 13);
        end
        return res;
    endfunction

endpackage

// ===== sv/f2h_if.sv =====
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for conversion requests and results.
// ----------------------------------------------------------------------------
interface f2h_req_if import f2h_pkg::*; (input logic i_clk);
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [OperandWidth-1:0] operand_bits;
    modport source (output valid, kind, operand_bits, input ready);
    modport sink (input valid, kind, operand_bits, output ready);
endinterface

interface f2h_rsp_if import f2h_pkg::*; (input logic i_clk);
    logic                   valid;
    logic                   ready;
    logic [ResultWidth-1:0] result_bits;
    modport source (output valid, result_bits, input ready);
    modport sink (input valid, result_bits, output ready);
endinterface

// ===== sv/fp32_fp16_converter_top.sv =====
// ----------------------------------------------------------------------------
// Binary32/binary16 converter
// Converts IEEE 754 single to half with round to nearest even, or half to
// single exactly. One transaction is accepted every cycle unless the output
// stalls. A request is first captured in the input register, and its result
// is then loaded into the result register when that register advances. The
// input register advances only when the result register is empty or its
// result is taken, unless the input register is itself empty.
// ----------------------------------------------------------------------------
module fp32_fp16_converter_top import f2h_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    f2h_req_if.sink   i_req,
    f2h_rsp_if.source o_rsp
);
    logic                    r_in_valid;
    logic                    r_kind;
    logic [OperandWidth-1:0] r_operand;
    logic                    r_out_valid;
    logic [ResultWidth-1:0]  r_result;
    logic [ResultWidth-1:0]  n_result;
    logic                    w_adv;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_adv || !r_in_valid;

    always_comb begin
        if (r_kind == KindToSingle) begin
            n_result = half_to_single(r_operand[15:0]);
        end else begin
            n_result = {16'd0, single_to_half(r_operand)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
        end
        if (i_req.ready && i_req.valid) begin
            r_kind    <= i_req.kind;
            r_operand <= i_req.operand_bits;
        end
        if (w_adv && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_bits = r_result;
endmodule

// ===== sv/f2h_checker.sv =====
// ----------------------------------------------------------------------------
// Converter checker
// Port-level properties of the converter top level.
// ----------------------------------------------------------------------------
module f2h_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_bits,
    input logic        i_in_kind
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bits))
        else $error("Stalled result changed.");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("Input stalled while output free.");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("Result missing.");
    a_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_kind && i_out_ready ##1 i_out_ready
        |=> i_out_bits[31:16] == 16'd0)
        else $error("Half result not zero-extended.");
endmodule

bind fp32_fp16_converter_top f2h_port_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_req.valid), .i_in_ready(i_req.ready),
    .i_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
    .i_out_bits(o_rsp.result_bits), .i_in_kind(i_req.kind)
);
